FILE: design/m3cf_pkg.sv
// Shared types and constants for the 3x3 complex FIR channel.
`default_nettype none
package m3cf_pkg;

    // Default sizes, handed down as top-level parameter defaults
    localparam int TAPS_DEF        = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    localparam int NCH     = 3;
    localparam int NPATH   = 9;
    localparam int PATH_W  = 4;
    localparam int TIU_W   = 9;
    localparam int SHIFT_W = 5;
    localparam int CFG_W   = 9;

    // Configuration register indexes
    localparam logic CFG_TAPS_IN_USE  = 1'b0;
    localparam logic CFG_RESULT_SHIFT = 1'b1;

    // Request kinds on tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Control that travels with operands into the MAC
    typedef struct packed {
        logic       valid;
        logic       clear;
        logic [1:0] ridx;
    } mac_ctrl_t;

endpackage
`default_nettype wire

FILE: design/mimo_3x3_complex_fir_channel.sv
// Top level of the 3x3 complex FIR channel: sequencer, history and coefficient memories.
`default_nettype none
// A sample request first stores the new samples, then runs one complex MAC for each
// path and active tap (one complex MAC per cycle on a single shared unit), then drains
// and scales. Coefficient requests are taken while idle.
// The history reads as zero until written (tracked by a fill
// count, no clearing pass). tready is low while a sample is being processed; a finished
// result waits in the output register while the next request is taken.
module mimo_3x3_complex_fir_channel
    import m3cf_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF,
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int IN_W   = 6*SAMPLE_BITS + PATH_W + TAP_W + 2*COEF_BITS,
    localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_DW = ((6*SAMPLE_BITS + 7) / 8) * 8
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // ch0_re, ch0_im, ch1_re, ch1_im, ch2_re, ch2_im, coef_path, coef_tap, coef_re, coef_im
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    // action
    input  wire logic              s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // out0_re, out0_im, out1_re, out1_im, out2_re, out2_im
    output logic [OUT_DW-1:0]      m_axis_tdata,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int HD    = NCH * TAPS;
    localparam int CD    = NPATH * TAPS;
    localparam int HA_W  = $clog2(HD);
    localparam int CA_W  = $clog2(CD);
    localparam int OFF_PATH = 6*SAMPLE_BITS;
    localparam int OFF_TAP  = OFF_PATH + PATH_W;
    localparam int OFF_CRE  = OFF_TAP + TAP_W;
    localparam int OFF_CIM  = OFF_CRE + COEF_BITS;
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + 2 + $clog2(NCH*TAPS);

    // Configuration registers
    logic [TIU_W-1:0]   taps_in_use_reg;
    logic [SHIFT_W-1:0] result_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_in_use_reg  <= TIU_W'(256);
            result_shift_reg <= SHIFT_W'(15);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAPS_IN_USE:  taps_in_use_reg  <= cfg_data[TIU_W-1:0];
                CFG_RESULT_SHIFT: result_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer state
    state_t state_reg, state_next;
    logic [1:0]       t_reg, t_next, r_reg, r_next, drain_reg, drain_next;
    logic [CNT_W-1:0] m_reg, m_next, age_reg, age_next, n_reg, n_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [TAP_W-1:0] hidx_reg, hidx_next, pos_reg, pos_next;
    logic [2*SAMPLE_BITS-1:0] smp_reg [NCH];
    logic             m_valid_reg, m_valid_next;
    logic [OUT_DW-1:0] m_data_reg;

    logic accept, smp_accept, coef_accept, out_free, load_out;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W:0]   start_sum;
    logic [TAP_W-1:0] start_idx;
    logic             last_issue;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign smp_accept  = accept && (s_axis_tuser == ACT_SAMPLE);
    assign coef_accept = accept && (s_axis_tuser == ACT_COEF);
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign load_out    = (state_reg == ST_DONE) && out_free;
    assign last_issue  = (t_reg == 2'd2) && (r_reg == 2'd2) && (m_reg == n_reg - 1'b1);

    // Clamp active taps to 1..TAPS
    always_comb
    begin
        if (taps_in_use_reg == '0)
            n_eff = CNT_W'(1);
        else if (32'(taps_in_use_reg) > TAPS)
            n_eff = CNT_W'(TAPS);
        else
            n_eff = CNT_W'(taps_in_use_reg);
    end

    // Oldest sample index: pos - (n-1) modulo TAPS
    assign start_sum = (CNT_W+1)'(pos_reg) + (CNT_W+1)'(TAPS) - (CNT_W+1)'(n_eff - 1'b1);
    assign start_idx = (32'(start_sum) >= TAPS) ? TAP_W'(32'(start_sum) - TAPS)
                                                : TAP_W'(start_sum);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (smp_accept) state_next = ST_WRITE;
            ST_WRITE: if (t_reg == 2'd2) state_next = ST_RUN;
            ST_RUN:   if (last_issue) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_reg == 2'd2) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Counters and outputs of the sequencer
    always_comb
    begin
        t_next       = t_reg;
        r_next       = r_reg;
        m_next       = m_reg;
        age_next     = age_reg;
        n_next       = n_reg;
        hidx_next    = hidx_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        drain_next   = drain_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (smp_accept)
                begin
                    t_next    = 2'd0;
                    r_next    = 2'd0;
                    m_next    = '0;
                    n_next    = n_eff;
                    age_next  = n_eff - 1'b1;
                    hidx_next = start_idx;
                end
            end
            ST_WRITE:
            begin
                if (t_reg == 2'd2)
                begin
                    t_next   = 2'd0;
                    pos_next = (32'(pos_reg) == TAPS - 1) ? '0 : pos_reg + 1'b1;
                    if (32'(fill_reg) < TAPS)
                        fill_next = fill_reg + 1'b1;
                end
                else
                    t_next = t_reg + 1'b1;
            end
            ST_RUN:
            begin
                drain_next = 2'd0;
                if (r_reg == 2'd2)
                begin
                    r_next = 2'd0;
                    if (t_reg == 2'd2)
                    begin
                        t_next    = 2'd0;
                        m_next    = m_reg + 1'b1;
                        age_next  = age_reg - 1'b1;
                        hidx_next = (32'(hidx_reg) == TAPS - 1) ? '0 : hidx_reg + 1'b1;
                    end
                    else
                        t_next = t_reg + 1'b1;
                end
                else
                    r_next = r_reg + 1'b1;
            end
            ST_DRAIN: drain_next = drain_reg + 1'b1;
            ST_DONE:  if (out_free) m_valid_next = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            t_reg       <= '0;
            r_reg       <= '0;
            m_reg       <= '0;
            age_reg     <= '0;
            n_reg       <= CNT_W'(1);
            hidx_reg    <= '0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            r_reg       <= r_next;
            m_reg       <= m_next;
            age_reg     <= age_next;
            n_reg       <= n_next;
            hidx_reg    <= hidx_next;
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Latch the incoming samples
    always_ff @(posedge clk)
    begin
        if (smp_accept)
            for (int t = 0; t < NCH; t++)
                smp_reg[t] <= s_axis_tdata[2*t*SAMPLE_BITS +: 2*SAMPLE_BITS];
    end

    // History memory: {im, re} per entry, channel-major
    logic [2*SAMPLE_BITS-1:0] hist_mem [HD];
    logic [2*SAMPLE_BITS-1:0] hist_q_reg;
    logic [HA_W-1:0] hist_waddr, hist_raddr;

    assign hist_waddr = HA_W'(32'(t_reg) * TAPS + 32'(pos_reg));
    assign hist_raddr = HA_W'(32'(t_reg) * TAPS + 32'(hidx_reg));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            hist_mem[hist_waddr] <= smp_reg[t_reg];
        hist_q_reg <= hist_mem[hist_raddr];
    end

    // Coefficient memory: {im, re} per entry, path-major
    logic [2*COEF_BITS-1:0] coef_mem [CD];
    logic [2*COEF_BITS-1:0] coef_q_reg;
    logic [PATH_W-1:0] in_path;
    logic [TAP_W-1:0]  in_tap;
    logic [CA_W-1:0]   coef_waddr, coef_raddr;
    logic              coef_wen;

    assign in_path    = s_axis_tdata[OFF_PATH +: PATH_W];
    assign in_tap     = s_axis_tdata[OFF_TAP +: TAP_W];
    assign coef_wen   = coef_accept && (32'(in_path) < NPATH) && (32'(in_tap) < TAPS);
    assign coef_waddr = CA_W'(32'(in_path) * TAPS + 32'(in_tap));
    assign coef_raddr = CA_W'((32'(t_reg) * NCH + 32'(r_reg)) * TAPS + 32'(m_reg));

    always_ff @(posedge clk)
    begin
        if (coef_wen)
            coef_mem[coef_waddr] <= {s_axis_tdata[OFF_CIM +: COEF_BITS],
                                     s_axis_tdata[OFF_CRE +: COEF_BITS]};
        coef_q_reg <= coef_mem[coef_raddr];
    end

    // Control aligned with the registered memory reads
    mac_ctrl_t ctrl0, ctrl1_reg;
    logic      hv_reg;

    always_comb
    begin
        ctrl0.valid = (state_reg == ST_RUN);
        ctrl0.clear = smp_accept;
        ctrl0.ridx  = r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            hv_reg    <= 1'b0;
        end
        else
        begin
            ctrl1_reg <= ctrl0;
            hv_reg    <= age_reg < fill_reg;
        end
    end

    // Samples never written read as zero
    logic signed [SAMPLE_BITS-1:0] op_sre, op_sim;
    assign op_sre = hv_reg ? hist_q_reg[SAMPLE_BITS-1:0] : '0;
    assign op_sim = hv_reg ? hist_q_reg[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;

    logic signed [ACC_W-1:0] acc_re [NCH];
    logic signed [ACC_W-1:0] acc_im [NCH];

    m3cf_cmac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_W       (ACC_W)
    ) u_cmac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl1_reg),
        .s_re   (op_sre),
        .s_im   (op_sim),
        .c_re   (coef_q_reg[COEF_BITS-1:0]),
        .c_im   (coef_q_reg[2*COEF_BITS-1:COEF_BITS]),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    // Scale and saturate one accumulator
    function automatic logic [SAMPLE_BITS-1:0] scale_sat(input logic signed [ACC_W-1:0] a,
                                                        input logic [SHIFT_W-1:0] sh);
        logic signed [ACC_W-1:0] v;
        logic [ACC_W-SAMPLE_BITS:0] top;
        v   = a >>> sh;
        top = v[ACC_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            scale_sat = v[SAMPLE_BITS-1:0];
        else if (v[ACC_W-1])
            scale_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            scale_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    // Scaled outputs, padding bits zero
    logic [OUT_DW-1:0] m_data_next;

    always_comb
    begin
        m_data_next = '0;
        for (int r = 0; r < NCH; r++)
        begin
            m_data_next[2*r*SAMPLE_BITS +: SAMPLE_BITS] =
                scale_sat(acc_re[r], result_shift_reg);
            m_data_next[(2*r+1)*SAMPLE_BITS +: SAMPLE_BITS] =
                scale_sat(acc_im[r], result_shift_reg);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
            m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // Tap and age counters stay complementary during the MAC loop
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (m_reg + age_reg) == (n_reg - 1'b1))
        else $error("tap/age counters out of step");

    // Fill count never passes the history depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= TAPS)
        else $error("history fill count overflow");

    // A new result appears only after the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // Operands only reach the MAC while the loop runs or drains
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl1_reg.valid |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("MAC operand outside loop");
`endif

endmodule
`default_nettype wire

FILE: design/m3cf_cmac.sv
// Shared complex multiply-accumulate unit with three complex accumulators.
`default_nettype none
module m3cf_cmac
    import m3cf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF,
    parameter int ACC_W       = 48
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mac_ctrl_t                     ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] s_re,
    input  wire logic signed [SAMPLE_BITS-1:0] s_im,
    input  wire logic signed [COEF_BITS-1:0]   c_re,
    input  wire logic signed [COEF_BITS-1:0]   c_im,
    output logic signed [ACC_W-1:0]            acc_re [NCH],
    output logic signed [ACC_W-1:0]            acc_im [NCH]
);

    localparam int PW = SAMPLE_BITS + COEF_BITS;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    mac_ctrl_t            ctrl_reg;
    logic signed [ACC_W-1:0] sum_re, sum_im;

    // Product stage
    always_ff @(posedge clk)
    begin
        p_rr_reg <= s_re * c_re;
        p_ii_reg <= s_im * c_im;
        p_ri_reg <= s_re * c_im;
        p_ir_reg <= s_im * c_re;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl;
    end

    // Complex combine
    assign sum_re = ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
    assign sum_im = ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);

    // Accumulate into the selected output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NCH; r++)
            begin
                acc_re[r] <= '0;
                acc_im[r] <= '0;
            end
        end
        else if (ctrl_reg.clear)
        begin
            for (int r = 0; r < NCH; r++)
            begin
                acc_re[r] <= '0;
                acc_im[r] <= '0;
            end
        end
        else if (ctrl_reg.valid)
        begin
            for (int r = 0; r < NCH; r++)
            begin
                if (ctrl_reg.ridx == 2'(r))
                begin
                    acc_re[r] <= acc_re[r] + sum_re;
                    acc_im[r] <= acc_im[r] + sum_im;
                end
            end
        end
    end

endmodule
`default_nettype wire
